// ----- rtl/b64lw_pkg.sv -----
// Package for the line-wrapping Base64 encoder: constants, job type, alphabet lookup.
// Depends on nothing; used by every other file of the block but the interface file.
`default_nettype none
package b64lw_pkg;

   localparam int unsigned LINE_CHARS = 76;
   localparam int unsigned LINE_CNT_W = 7;
   localparam int unsigned SUM_W      = LINE_CNT_W + 1;

   localparam logic [7:0] CHAR_CR  = 8'd13;
   localparam logic [7:0] CHAR_LF  = 8'd10;
   localparam logic [7:0] CHAR_PAD = 8'd61;

   localparam logic [1:0] POS_EMPTY = 2'd0;
   localparam logic [1:0] POS_ONE   = 2'd1;
   localparam logic [1:0] POS_TWO   = 2'd2;

   localparam logic [2:0] IDX_FIRST    = 3'd0;
   localparam logic [2:0] IDX_CR       = 3'd4;
   localparam logic [2:0] IDX_LAST_GRP = 3'd3;
   localparam logic [2:0] IDX_LAST_BRK = 3'd5;

   // one queued unit of output work: up to four sextets, padding, optional CR LF
   typedef struct packed {
      logic [0:3][5:0] sext;
      logic [1:0]      pad_cnt;
      logic            brk;
      logic            fin;
   } job_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'd65 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'd71 + {2'b00, v};
      end else if (v < 6'd62) begin
         c = {2'b00, v} - 8'd4;
      end else if (v == 6'd62) begin
         c = 8'd43;
      end else begin
         c = 8'd47;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/b64lw_if.sv -----
// Handshake channels of the encoder: byte input and character output.
// Depends on nothing.
`default_nettype none
interface b64lw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;
   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64lw_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       run_last;
   logic       message_done;
   modport source (output valid, output out_char, output run_last, output message_done,
                   input ready);
   modport sink (input valid, input out_char, input run_last, input message_done,
                 output ready);
endinterface
`default_nettype wire

// ----- rtl/b64lw_front.sv -----
// Front end: takes bytes, holds partial groups, tracks line length, builds jobs.
// Depends on b64lw_pkg and b64lw_if.
`default_nettype none
module b64lw_front (
   input  wire logic             clock,
   input  wire logic             reset,
   b64lw_req_if.sink             req_if,
   input  wire logic             q_full,
   output logic                  push,
   output b64lw_pkg::job_type    push_job
);
   import b64lw_pkg::*;

   logic [7:0]            held_ff [2];
   logic [1:0]            pos_ff, pos_in;
   logic [LINE_CNT_W-1:0] line_ff, line_in;
   logic                  accept;
   logic [SUM_W-1:0]      sum;
   logic [7:0]            b;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && !q_full;
   assign b            = req_if.data_byte;
   assign sum          = {1'b0, line_ff} + SUM_W'(4);

   always_comb begin
      push_job = '0;
      push     = 1'b0;
      pos_in   = pos_ff;
      line_in  = line_ff;
      push_job.fin = req_if.final_byte;
      if (pos_ff == POS_TWO) begin
         push_job.sext[0] = held_ff[0][7:2];
         push_job.sext[1] = {held_ff[0][1:0], held_ff[1][7:4]};
         push_job.sext[2] = {held_ff[1][3:0], b[7:6]};
         push_job.sext[3] = b[5:0];
         push_job.brk     = (sum >= SUM_W'(LINE_CHARS));
         push             = accept;
         pos_in           = POS_EMPTY;
         line_in          = push_job.brk ? '0 : sum[LINE_CNT_W-1:0];
      end else if (req_if.final_byte && pos_ff == POS_EMPTY) begin
         push_job.sext[0] = b[7:2];
         push_job.sext[1] = {b[1:0], 4'b0000};
         push_job.pad_cnt = 2'd2;
         push             = accept;
      end else if (req_if.final_byte) begin
         push_job.sext[0] = held_ff[0][7:2];
         push_job.sext[1] = {held_ff[0][1:0], b[7:4]};
         push_job.sext[2] = {b[3:0], 2'b00};
         push_job.pad_cnt = 2'd1;
         push             = accept;
      end else begin
         pos_in = pos_ff + 2'd1;
      end
      if (req_if.final_byte) begin
         pos_in  = POS_EMPTY;
         line_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !req_if.final_byte && pos_ff != POS_TWO) begin
         held_ff[pos_ff[0]] <= b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_EMPTY;
         line_ff <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         line_ff <= line_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/b64lw_fifo.sv -----
// Two-entry job queue between front and back end.
// Depends on b64lw_pkg.
`default_nettype none
module b64lw_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire b64lw_pkg::job_type push_job,
   input  wire logic             pop,
   output b64lw_pkg::job_type    head_job,
   output logic                  full,
   output logic                  empty
);
   import b64lw_pkg::*;

   job_type    mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign head_job = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

endmodule
`default_nettype wire

// ----- rtl/b64lw_back.sv -----
// Back end: a job becomes characters in the output register, one per cycle when ready.
// Depends on b64lw_pkg and b64lw_if.
`default_nettype none
module b64lw_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire b64lw_pkg::job_type head_job,
   input  wire logic             empty,
   output logic                  pop,
   b64lw_rsp_if.source           rsp_if
);
   import b64lw_pkg::*;

   logic [2:0] idx_ff;
   logic       valid_ff;
   logic [7:0] char_ff, char_in;
   logic       last_ff, done_ff;
   logic       adv, last;
   logic [2:0] pad_sum;

   assign adv     = !empty && (!valid_ff || rsp_if.ready);
   assign last    = (idx_ff == (head_job.brk ? IDX_LAST_BRK : IDX_LAST_GRP));
   assign pop     = adv && last;
   assign pad_sum = {1'b0, idx_ff[1:0]} + {1'b0, head_job.pad_cnt};

   always_comb begin
      if (idx_ff == IDX_CR) begin
         char_in = CHAR_CR;
      end else if (idx_ff > IDX_CR) begin
         char_in = CHAR_LF;
      end else if (pad_sum[2]) begin
         char_in = CHAR_PAD;
      end else begin
         char_in = sextet_char(head_job.sext[idx_ff[1:0]]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         char_ff <= char_in;
         last_ff <= last;
         done_ff <= last && head_job.fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= IDX_FIRST;
      end else begin
         if (adv) begin
            valid_ff <= 1'b1;
            idx_ff   <= last ? IDX_FIRST : idx_ff + 3'd1;
         end else if (rsp_if.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid        = valid_ff;
   assign rsp_if.out_char     = char_ff;
   assign rsp_if.run_last     = last_ff;
   assign rsp_if.message_done = done_ff;

endmodule
`default_nettype wire

// ----- rtl/base64_encoder_line_wrap.sv -----
// Streaming Base64 encoder with CR LF after every LINE_CHARS group characters.
// An item's first character passes through the job queue and then the output register.
// The back end gives one character per cycle while the receiver is ready, 4 or 6 for
// an emitting item; bytes that only fill the group are taken every cycle while the
// two-entry queue has room.
// Reset (synchronous): clears group position, line count, queue and output valid.
`default_nettype none
module base64_encoder_line_wrap (
   input  wire logic    clock,
   input  wire logic    reset,
   b64lw_req_if.sink    req_if,
   b64lw_rsp_if.source  rsp_if
);
   import b64lw_pkg::*;

   logic    push, pop, q_full, q_empty;
   job_type push_job, head_job;

   b64lw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .q_full   (q_full),
      .push     (push),
      .push_job (push_job)
   );

   b64lw_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   b64lw_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .empty    (q_empty),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_full && !pop)) else $error("job queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_empty)) else $error("job queue underflow");
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.message_done) |-> rsp_if.run_last)
      else $error("message end not on last character of item");
`endif

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Testbench for base64_encoder_line_wrap: directed and random messages through the byte channel,
// characters checked against an in-bench Base64/line-wrap predictor.
// Depends on rtl/b64lw_pkg.sv, rtl/b64lw_if.sv and rtl/base64_encoder_line_wrap.sv.
`timescale 1ns / 1ps
module tb;
   import b64lw_pkg::*;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } msg_byte_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       run_last;
      logic       message_done;
   } enc_char_type;

   localparam string B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam int TARGET_ITEMS = 450;

   logic clock;
   logic reset;

   b64lw_req_if req_ch ();
   b64lw_rsp_if rsp_ch ();

   base64_encoder_line_wrap DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   msg_byte_type  msg_byte_q[$];
   enc_char_type  enc_char_q[$];
   int         items_total = 0;
   int         items_accepted = 0;
   int         mismatches = 0;
   logic       req_taken = 1'b0;
   logic       hold_rsp;

   // encoder state mirror
   logic [7:0] held_byte[2];
   logic [1:0] group_pos = POS_EMPTY;
   int         line_count = 0;

   int burst_left = 0;
   int gap_left = 0;
   int rsp_mode = 0;
   int rsp_window = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $time, what);
      mismatches++;
   endtask

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      return B64_ALPHABET[v];
   endfunction

   task automatic encode_byte(input logic [7:0] b, input logic fin);
      logic [7:0]   chars[6];
      int           n;
      int           cnt;
      enc_char_type ec;
      n = 0;
      if (group_pos == POS_TWO) begin
         chars[0] = b64_char(held_byte[0][7:2]);
         chars[1] = b64_char({held_byte[0][1:0], held_byte[1][7:4]});
         chars[2] = b64_char({held_byte[1][3:0], b[7:6]});
         chars[3] = b64_char(b[5:0]);
         n = 4;
         cnt = line_count + 4;
         if (cnt >= LINE_CHARS) begin
            chars[4] = CHAR_CR;
            chars[5] = CHAR_LF;
            n = 6;
            cnt = 0;
         end
         line_count = cnt;
         group_pos = POS_EMPTY;
      end else if (fin && group_pos == POS_EMPTY) begin
         chars[0] = b64_char(b[7:2]);
         chars[1] = b64_char({b[1:0], 4'h0});
         chars[2] = CHAR_PAD;
         chars[3] = CHAR_PAD;
         n = 4;
      end else if (fin) begin
         chars[0] = b64_char(held_byte[0][7:2]);
         chars[1] = b64_char({held_byte[0][1:0], b[7:4]});
         chars[2] = b64_char({b[3:0], 2'b00});
         chars[3] = CHAR_PAD;
         n = 4;
      end else begin
         held_byte[group_pos[0]] = b;
         group_pos = group_pos + 2'd1;
      end
      for (int i = 0; i < n; i++) begin
         ec = '{chars[i], i == n - 1, fin && (i == n - 1)};
         enc_char_q = {enc_char_q, ec};
      end
      if (fin) begin
         group_pos = POS_EMPTY;
         line_count = 0;
      end
   endtask

   task automatic queue_message(input int len);
      msg_byte_type mb;
      for (int i = 0; i < len; i++) begin
         mb = '{8'($urandom_range(0, 255)), i == len - 1};
         msg_byte_q = {msg_byte_q, mb};
      end
      items_total += len;
   endtask

   task automatic queue_fixed(input logic [7:0] b, input logic fin);
      msg_byte_type mb;
      mb = '{b, fin};
      msg_byte_q = {msg_byte_q, mb};
      items_total++;
   endtask

   // driver: bursts with random gaps
   always @(negedge clock) begin
      msg_byte_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (gap_left > 0 && !hold_rsp) begin
            req_ch.valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (msg_byte_q.size() > 0) begin
            nxt = msg_byte_q.pop_front();
            req_ch.valid      <= 1'b1;
            req_ch.data_byte  <= nxt.data_byte;
            req_ch.final_byte <= nxt.final_byte;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 48);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, switched in windows
   always @(negedge clock) begin
      if (rsp_window == 0) begin
         rsp_mode   <= $urandom_range(0, 3);
         rsp_window <= $urandom_range(16, 96);
      end else begin
         rsp_window <= rsp_window - 1;
      end
      case (rsp_mode)
         0: rsp_ch.ready <= !hold_rsp;
         1: rsp_ch.ready <= !hold_rsp && ($urandom_range(0, 1) == 0);
         2: rsp_ch.ready <= !hold_rsp && ($urandom_range(0, 3) == 0);
         default: rsp_ch.ready <= !hold_rsp && ($urandom_range(0, 3) != 0);
      endcase
   end

   // long receiver hold-off so the encoder backs up into its input
   initial begin
      hold_rsp = 1'b0;
      wait (items_accepted >= 120);
      @(negedge clock);
      hold_rsp <= 1'b1;
      repeat (400) @(negedge clock);
      hold_rsp <= 1'b0;
   end

   // monitor: predict on accepted items, check accepted characters
   always @(posedge clock) begin
      enc_char_type exp_c;
      req_taken <= req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         encode_byte(req_ch.data_byte, req_ch.final_byte);
         items_accepted++;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (enc_char_q.size() == 0) begin
            report_mismatch($sformatf("unexpected char 0x%02h", rsp_ch.out_char));
         end else begin
            exp_c = enc_char_q.pop_front();
            if (rsp_ch.out_char !== exp_c.out_char)
               report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                         rsp_ch.out_char, exp_c.out_char));
            if (rsp_ch.run_last !== exp_c.run_last)
               report_mismatch($sformatf("run_last %0b, expected %0b (char 0x%02h)",
                                         rsp_ch.run_last, exp_c.run_last, exp_c.out_char));
            if (rsp_ch.message_done !== exp_c.message_done)
               report_mismatch($sformatf("message_done %0b, expected %0b (char 0x%02h)",
                                         rsp_ch.message_done, exp_c.message_done,
                                         exp_c.out_char));
         end
      end
   end

   initial begin
      #500000;
      $display("base64_encoder_line_wrap test failed");
      $finish;
   end

   initial begin
      int kind;
      req_ch.valid      = 1'b0;
      req_ch.data_byte  = 8'h00;
      req_ch.final_byte = 1'b0;
      rsp_ch.ready      = 1'b0;
      reset             = 1'b1;

      // one-byte, two-byte and full-group final items at the byte extremes
      queue_fixed(8'h00, 1'b1);
      queue_fixed(8'hFF, 1'b1);
      queue_fixed(8'hFF, 1'b0);
      queue_fixed(8'h00, 1'b1);
      queue_fixed(8'h00, 1'b0);
      queue_fixed(8'hFF, 1'b1);
      queue_fixed(8'hFF, 1'b0);
      queue_fixed(8'hFF, 1'b0);
      queue_fixed(8'hFF, 1'b1);
      queue_fixed(8'h00, 1'b0);
      queue_fixed(8'h00, 1'b0);
      queue_fixed(8'h00, 1'b1);
      // "++++" group, then a two-byte tail
      queue_fixed(8'hFB, 1'b0);
      queue_fixed(8'hEF, 1'b0);
      queue_fixed(8'hBE, 1'b0);
      queue_fixed(8'h00, 1'b0);
      queue_fixed(8'h10, 1'b1);

      // exactly one full line: CR LF closes the message
      queue_message(57);
      while (items_total < TARGET_ITEMS) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2, 3: queue_message($urandom_range(1, 6));
            4, 5:       queue_message(3 * $urandom_range(1, 10));
            6, 7:       queue_message($urandom_range(7, 40));
            8:          queue_message(57 * $urandom_range(1, 2));
            default:    queue_message($urandom_range(60, 130));
         endcase
      end

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      while (items_accepted < items_total || enc_char_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("base64_encoder_line_wrap test passed");
      end else begin
         $display("base64_encoder_line_wrap test failed");
      end
      $finish;
   end

endmodule

// ----- base64_encoder_line_wrap.f -----
rtl/b64lw_pkg.sv
rtl/b64lw_if.sv
rtl/b64lw_front.sv
rtl/b64lw_fifo.sv
rtl/b64lw_back.sv
rtl/base64_encoder_line_wrap.sv
verif/tb.sv
